@@ hdl/amg_pkg.sv @@
package amg_pkg;

  localparam int unsigned MAX_SEQ = 8192;
  localparam int unsigned WINDOW  = 512;

  localparam int unsigned LEN_W   = 14;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned TOK_W   = 32;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // suffix detection constants
  localparam int unsigned BLOCK_BITS  = 6;
  localparam int unsigned SHORT_LIMIT = 8;

  localparam logic [LEN_W-1:0] MAX_SEQ_LEN = LEN_W'(MAX_SEQ);
  localparam logic [LEN_W-1:0] LEN_RESET   = LEN_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_POSITION  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKENS_PRESENT = 3'd4;

  localparam logic signed [CODE_W-1:0] NARROW_VALID  = 16'sd127;
  localparam logic signed [CODE_W-1:0] NARROW_MASKED = -16'sd128;
  localparam logic signed [CODE_W-1:0] WIDE_VALID    = 16'sd0;
  localparam logic signed [CODE_W-1:0] WIDE_MASKED   = -16'sd32767;

  localparam logic signed [TOK_W-1:0] TOKEN_INVALID = -32'sd1;

  typedef struct packed {
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [TOK_W-1:0] draft_token;
  } in_item_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] local_value;
    logic signed [CODE_W-1:0] global_value;
  } out_item_t;

  // mask geometry and mode settled from the configuration registers
  typedef struct packed {
    logic [LEN_W-1:0]  seq_q;
    logic [LEN_W-1:0]  seq_k;
    logic [LEN_W-1:0]  capacity;
    logic              suffix;
    logic [STEP_W-1:0] step;
    logic              wide;
    logic              tokens_present;
  } geom_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    clamp_len = (v > MAX_SEQ_LEN) ? MAX_SEQ_LEN : v;
  endfunction

endpackage

@@ hdl/amg_eval.sv @@
module amg_eval (
  input  amg_pkg::geom_t    geom,
  input  amg_pkg::in_item_t item,
  output amg_pkg::out_item_t result
);
  import amg_pkg::*;

  localparam int unsigned SUM_W = STEP_W + 2;

  logic [LEN_W-1:0] q_ext;
  logic [LEN_W-1:0] k_ext;
  logic             in_range;
  logic             in_cache;
  logic             below_limit;
  logic             in_window;
  logic [LEN_W-1:0] rel;
  logic             suffix_ok;
  logic             tok_ok;
  logic             lv;
  logic             gv;
  logic [SUM_W-1:0] k_plus_win;
  logic [SUM_W-1:0] ts_plus_q;
  logic signed [CODE_W-1:0] valid_code;
  logic signed [CODE_W-1:0] masked_code;

  always_comb begin
    q_ext    = LEN_W'(item.row_index);
    k_ext    = LEN_W'(item.col_index);
    in_range = (q_ext < geom.seq_q) && (k_ext < geom.seq_k);
    in_cache = k_ext < geom.capacity;

    // limit is ts with a suffix, ts + 1 without
    if (geom.suffix) begin
      below_limit = STEP_W'(k_ext) < geom.step;
    end else begin
      below_limit = STEP_W'(k_ext) <= geom.step;
    end

    // k >= ts + q - (window - 1), rearranged to stay unsigned
    k_plus_win = SUM_W'(k_ext) + SUM_W'(WINDOW - 1);
    ts_plus_q  = SUM_W'(geom.step) + SUM_W'(q_ext);
    in_window  = k_plus_win >= ts_plus_q;

    rel       = k_ext - geom.capacity;
    tok_ok    = !geom.tokens_present || (item.draft_token != TOKEN_INVALID);
    suffix_ok = geom.suffix && (rel < geom.seq_q) && (rel <= q_ext) && tok_ok;

    gv = 1'b0;
    lv = 1'b0;
    if (in_range) begin
      if (in_cache) begin
        gv = below_limit;
        lv = below_limit && in_window;
      end else begin
        gv = suffix_ok;
        lv = suffix_ok;
      end
    end

    valid_code  = geom.wide ? WIDE_VALID : NARROW_VALID;
    masked_code = geom.wide ? WIDE_MASKED : NARROW_MASKED;

    result.local_value  = lv ? valid_code : masked_code;
    result.global_value = gv ? valid_code : masked_code;
  end

endmodule

@@ hdl/attention_mask_generator.sv @@
// attention mask element generator
// start/in_item: one request per cycle carries a query row, a key column and
// the draft token of that column; it is taken at any edge with start high
// (busy stays low, the block never refuses a request)
// out_valid/out_item: one strobe per request with the local (sliding-window)
// and global mask codes; results come in request order
// pipeline: request register then result register, with the mask
// test between them; throughput: one element per cycle, set by that single
// registered pass
// cfg_wr_en/cfg_index/cfg_wdata: register writes land at once; the derived
// cache capacity, suffix flag and clamped lengths follow in the cycle after,
// so a request may follow a write in the next cycle
// reset: lengths go to 1, step, mode and token check to 0, and any request
// in flight is dropped
// the receiver cannot stall: each result shows for exactly one cycle
module attention_mask_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  amg_pkg::in_item_t                     in_item,
  output logic                                  out_valid,
  output amg_pkg::out_item_t                    out_item,
  input  logic                                  cfg_wr_en,
  input  logic [amg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [amg_pkg::CFG_W-1:0]             cfg_wdata
);
  import amg_pkg::*;

  logic [LEN_W-1:0]  query_len_r;
  logic [LEN_W-1:0]  key_len_r;
  logic [STEP_W-1:0] step_position_r;
  logic              wide_mode_r;
  logic              tokens_present_r;

  logic [LEN_W-1:0]  seq_q;
  logic [LEN_W-1:0]  seq_k;
  logic [LEN_W-1:0]  diff;
  logic [LEN_W-1:0]  floor_blk;
  logic [LEN_W-1:0]  cap_nxt;
  logic              suffix_nxt;
  logic [LEN_W-1:0]  cap_r;
  logic              suffix_r;
  logic [LEN_W-1:0]  seq_q_r;
  logic [LEN_W-1:0]  seq_k_r;

  logic              in_valid_r;
  in_item_t          in_r;
  geom_t             geom;
  out_item_t         result;
  logic              out_valid_r;
  out_item_t         out_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_len_r      <= LEN_RESET;
      key_len_r        <= LEN_RESET;
      step_position_r  <= '0;
      wide_mode_r      <= 1'b0;
      tokens_present_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_QUERY_LEN:      query_len_r      <= cfg_wdata[LEN_W-1:0];
        CFG_KEY_LEN:        key_len_r        <= cfg_wdata[LEN_W-1:0];
        CFG_STEP_POSITION:  step_position_r  <= cfg_wdata[STEP_W-1:0];
        CFG_WIDE_MODE:      wide_mode_r      <= cfg_wdata[0];
        CFG_TOKENS_PRESENT: tokens_present_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // cache capacity and suffix presence from the lengths
  always_comb begin
    seq_q      = clamp_len(query_len_r);
    seq_k      = clamp_len(key_len_r);
    diff       = seq_k - seq_q;
    floor_blk  = {seq_k[LEN_W-1:BLOCK_BITS], {BLOCK_BITS{1'b0}}};
    cap_nxt    = seq_k;
    suffix_nxt = 1'b0;
    if (seq_k > seq_q) begin
      if ((diff[BLOCK_BITS-1:0] == '0) || (seq_q > LEN_W'(SHORT_LIMIT))) begin
        cap_nxt    = diff;
        suffix_nxt = 1'b1;
      end else if ((seq_k[LEN_W-1:BLOCK_BITS] != '0) &&
                   (seq_k[BLOCK_BITS-1:0] != '0) &&
                   (seq_k[BLOCK_BITS-1:0] <= BLOCK_BITS'(SHORT_LIMIT))) begin
        cap_nxt    = floor_blk;
        suffix_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_r    <= cap_nxt;
    suffix_r <= suffix_nxt;
    seq_q_r  <= seq_q;
    seq_k_r  <= seq_k;
  end

  always_comb begin
    geom.seq_q          = seq_q_r;
    geom.seq_k          = seq_k_r;
    geom.capacity       = cap_r;
    geom.suffix         = suffix_r;
    geom.step           = step_position_r;
    geom.wide           = wide_mode_r;
    geom.tokens_present = tokens_present_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
    if (in_valid_r) begin
      out_r <= result;
    end
  end

  amg_eval u_eval (
    .geom   (geom),
    .item   (in_r),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
